// File: sv/uer_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block but uer_fifo
package uer_pkg;

  // trigger timing in ticks
  localparam int PRE_LOW_TICKS   = 2;
  localparam int TRIG_HIGH_TICKS = 10;
  localparam int PHASE_TICK_W    = 4;

  // default echo width counter size
  localparam int COUNT_BITS_DEF = 20;

  // field widths
  localparam int TIMEOUT_W = 20;
  localparam int DIST_W    = 18;

  // configuration register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd60000;
  localparam logic [DIST_W-1:0]    MIN_MM_RST  = 18'd20;
  localparam logic [DIST_W-1:0]    MAX_MM_RST  = 18'd4000;

  // apb port geometry
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // distance = width * 50 / 289, saturating at 2^18-1
  // widths above WIDTH_CLAMP all saturate, so clamp first to keep x narrow
  localparam int WC_W = 21;
  localparam int X_W  = 27;
  localparam int M_W  = 28;
  localparam int P_W  = X_W + M_W;
  localparam logic [WC_W-1:0] WIDTH_CLAMP = 21'd1515192;
  // ceil(2^36 / 289), exact for any x below 2^27
  localparam logic [M_W-1:0]  DIV_MUL     = 28'd237783657;
  localparam int              DIV_SHIFT   = 36;

  // decoupling queue between front and back
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRELOW   = 3'd1,
    PH_TRIGHI   = 3'd2,
    PH_WAITRISE = 3'd3,
    PH_MEASURE  = 3'd4
  } uer_phase_e;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MIN_MM  = 2'd1,
    REG_MAX_MM  = 2'd2
  } uer_reg_e;

  // per-tick outcome handed from front to back
  typedef struct packed {
    logic trig;
    logic done;
    logic timed_out;
    logic busy;
    logic fell;
  } uer_flags_t;

endpackage

// File: sv/ultrasonic_echo_ranger_top.sv
`timescale 1ns / 1ps
// Ultrasonic echo ranger. Each input transfer is one 1 us tick carrying
// start_req_i and the sampled echo level; each tick yields exactly one result
// transfer with the trigger level, done/timeout flags, distance and busy.
// Channels use valid/stall; a transfer happens when valid is high and stall
// low. The front sequencer handles one tick per cycle, so one transfer per
// cycle is sustained in and out while the receiver does not stall. A result
// passes through the queue, the scaling stage, the multiplier stage and the
// output register before it appears on the output.
// When the receiver stalls, the output register holds, the pipeline fills,
// then the four-entry queue fills and in_stall_o rises; nothing is dropped.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, empties
// the pipeline and loads timeout 60000, min 20 mm, max 4000 mm.
// Registers over APB at byte addresses 0 (timeout_ticks), 4 (min_valid_mm)
// and 8 (max_valid_mm); write only while the block is idle.
// Depends on uer_pkg, uer_front, uer_fifo, uer_back.
module ultrasonic_echo_ranger_top #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        start_req_i,
  input  logic                        echo_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        trig_o,
  output logic                        done_res_o,
  output logic [uer_pkg::DIST_W-1:0]  distance_mm_o,
  output logic                        in_range_o,
  output logic                        timed_out_o,
  output logic                        busy_res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uer_pkg::APB_AW-1:0]  paddr,
  input  logic [uer_pkg::APB_DW-1:0]  pwdata,
  output logic [uer_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  import uer_pkg::*;

  localparam int FLAGS_W = $bits(uer_flags_t);
  localparam int QW      = FLAGS_W + COUNT_BITS;

  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [DIST_W-1:0]     min_mm_q, max_mm_q;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;

  logic                  push, pop, q_valid, q_full;
  uer_flags_t            f_flags, q_flags;
  logic [COUNT_BITS-1:0] f_width, q_width;
  logic [QW-1:0]         q_wdata, q_rdata;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT: prdata = APB_DW'(timeout_q);
      REG_MIN_MM:  prdata = APB_DW'(min_mm_q);
      REG_MAX_MM:  prdata = APB_DW'(max_mm_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      min_mm_q  <= MIN_MM_RST;
      max_mm_q  <= MAX_MM_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
        REG_MIN_MM:  min_mm_q  <= pwdata[DIST_W-1:0];
        REG_MAX_MM:  max_mm_q  <= pwdata[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uer_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .start_req_i     (start_req_i),
    .echo_i          (echo_i),
    .timeout_ticks_i (timeout_q),
    .full_i          (q_full),
    .push_o          (push),
    .flags_o         (f_flags),
    .width_o         (f_width)
  );

  assign q_wdata = {f_flags, f_width};

  uer_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  assign q_flags = q_rdata[QW-1 -: FLAGS_W];
  assign q_width = q_rdata[COUNT_BITS-1:0];

  uer_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_flags_i      (q_flags),
    .q_width_i      (q_width),
    .q_pop_o        (pop),
    .min_valid_mm_i (min_mm_q),
    .max_valid_mm_i (max_mm_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trig_o         (trig_o),
    .done_res_o     (done_res_o),
    .distance_mm_o  (distance_mm_o),
    .in_range_o     (in_range_o),
    .timed_out_o    (timed_out_o),
    .busy_res_o     (busy_res_o)
  );

endmodule

// File: sv/uer_fifo.sv
`timescale 1ns / 1ps
// short register queue that decouples the ranger front from its back end
// no package dependencies
module uer_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/uer_front.sv
`timescale 1ns / 1ps
// ranger front: takes one tick per transfer, runs the trigger/echo sequencer
// and emits per-tick flags plus the echo width; uses uer_pkg
module uer_front #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_req_i,
  input  logic                           echo_i,
  input  logic [uer_pkg::TIMEOUT_W-1:0]  timeout_ticks_i,
  input  logic                           full_i,
  output logic                           push_o,
  output uer_pkg::uer_flags_t            flags_o,
  output logic [COUNT_BITS-1:0]          width_o
);

  import uer_pkg::*;

  uer_phase_e              phase_q, phase_d, ph_eff;
  logic [PHASE_TICK_W-1:0] ticks_q, ticks_d, tick_inc;
  logic [TIMEOUT_W-1:0]    wait_q, wait_d, wait_inc;
  logic [COUNT_BITS-1:0]   width_q, width_d;
  logic                    echo_prev_q, echo_prev_d;
  logic                    accept;
  logic                    rise, fell, tmo_hit;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign width_o    = width_q;

  // a start request from idle makes this tick the first pre-low tick
  always_comb begin
    ph_eff   = phase_q;
    tick_inc = ticks_q + 1'b1;
    if (phase_q == PH_IDLE && start_req_i) begin
      ph_eff   = PH_PRELOW;
      tick_inc = PHASE_TICK_W'(1);
    end
  end

  assign wait_inc = (&wait_q) ? wait_q : wait_q + 1'b1;
  assign rise     = echo_i && !echo_prev_q;
  assign fell     = (ph_eff == PH_MEASURE) && !echo_i;
  assign tmo_hit  = (wait_inc >= timeout_ticks_i);

  // next state
  always_comb begin
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    wait_d      = wait_q;
    width_d     = width_q;
    echo_prev_d = echo_prev_q;
    if (accept) begin
      echo_prev_d = echo_i;
      phase_d     = ph_eff;
      unique case (ph_eff)
        PH_IDLE: begin
        end
        PH_PRELOW: begin
          if (tick_inc >= PHASE_TICK_W'(PRE_LOW_TICKS)) begin
            phase_d = PH_TRIGHI;
            ticks_d = '0;
          end else begin
            ticks_d = tick_inc;
          end
        end
        PH_TRIGHI: begin
          if (tick_inc >= PHASE_TICK_W'(TRIG_HIGH_TICKS)) begin
            phase_d = PH_WAITRISE;
            ticks_d = '0;
            wait_d  = '0;
            width_d = '0;
          end else begin
            ticks_d = tick_inc;
          end
        end
        PH_WAITRISE, PH_MEASURE: begin
          wait_d = wait_inc;
          if (ph_eff == PH_WAITRISE && rise) begin
            phase_d = PH_MEASURE;
            width_d = COUNT_BITS'(1);
          end else if (ph_eff == PH_MEASURE && echo_i && !(&width_q)) begin
            width_d = width_q + 1'b1;
          end
          // falling edge wins over a timeout on the same tick
          if (fell || tmo_hit) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // per-tick outputs
  always_comb begin
    flags_o           = '0;
    flags_o.trig      = (ph_eff == PH_TRIGHI);
    flags_o.busy      = (phase_d != PH_IDLE);
    if (ph_eff == PH_WAITRISE || ph_eff == PH_MEASURE) begin
      flags_o.done      = fell || tmo_hit;
      flags_o.timed_out = !fell && tmo_hit;
      flags_o.fell      = fell;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      wait_q      <= '0;
      width_q     <= '0;
      echo_prev_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      wait_q      <= wait_d;
      width_q     <= width_d;
      echo_prev_q <= echo_prev_d;
    end
  end

endmodule

// File: sv/uer_back.sv
`timescale 1ns / 1ps
// ranger back end: three-stage pipeline that turns echo width into distance
// by reciprocal multiply, checks the bounds and holds the result; uses uer_pkg
module uer_back #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  uer_pkg::uer_flags_t         q_flags_i,
  input  logic [COUNT_BITS-1:0]       q_width_i,
  output logic                        q_pop_o,
  input  logic [uer_pkg::DIST_W-1:0]  min_valid_mm_i,
  input  logic [uer_pkg::DIST_W-1:0]  max_valid_mm_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        trig_o,
  output logic                        done_res_o,
  output logic [uer_pkg::DIST_W-1:0]  distance_mm_o,
  output logic                        in_range_o,
  output logic                        timed_out_o,
  output logic                        busy_res_o
);

  import uer_pkg::*;

  logic              a_valid_q, b_valid_q, c_valid_q;
  logic              a_adv, b_adv, c_adv;
  uer_flags_t        a_flags_q, b_flags_q;
  logic [X_W-1:0]    a_x_q, a_x_d;
  logic [P_W-1:0]    b_prod_q;
  logic [31:0]       w32;
  logic [WC_W-1:0]   wc;
  logic [X_W-1:0]    wcx;
  logic [DIST_W-1:0] quot_mm;
  logic              c_trig_q, c_done_q, c_inr_q, c_tmo_q, c_busy_q;
  logic [DIST_W-1:0] c_dist_q;

  // each stage moves when empty or when the next one moves
  assign c_adv   = !c_valid_q || !out_stall_i;
  assign b_adv   = !b_valid_q || c_adv;
  assign a_adv   = !a_valid_q || b_adv;
  assign q_pop_o = q_valid_i && a_adv;

  // stage a: clamp so the result saturates, then times 50 by shift-add
  assign w32   = 32'(q_width_i);
  assign wc    = (w32 > 32'(WIDTH_CLAMP)) ? WIDTH_CLAMP : w32[WC_W-1:0];
  assign wcx   = X_W'(wc);
  assign a_x_d = (wcx << 5) + (wcx << 4) + (wcx << 1);

  // stage c: quotient by 289
  assign quot_mm = b_prod_q[DIV_SHIFT +: DIST_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_adv) a_valid_q <= q_valid_i;
      if (b_adv) b_valid_q <= a_valid_q;
      if (c_adv) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && q_valid_i) begin
      a_flags_q <= q_flags_i;
      a_x_q     <= a_x_d;
    end
    if (b_adv && a_valid_q) begin
      b_flags_q <= a_flags_q;
      b_prod_q  <= P_W'(a_x_q) * P_W'(DIV_MUL);
    end
    if (c_adv && b_valid_q) begin
      c_trig_q <= b_flags_q.trig;
      c_done_q <= b_flags_q.done;
      c_tmo_q  <= b_flags_q.timed_out;
      c_busy_q <= b_flags_q.busy;
      c_dist_q <= b_flags_q.fell ? quot_mm : '0;
      c_inr_q  <= b_flags_q.fell && (quot_mm >= min_valid_mm_i)
                  && (quot_mm <= max_valid_mm_i);
    end
  end

  assign out_valid_o   = c_valid_q;
  assign trig_o        = c_trig_q;
  assign done_res_o    = c_done_q;
  assign distance_mm_o = c_dist_q;
  assign in_range_o    = c_inr_q;
  assign timed_out_o   = c_tmo_q;
  assign busy_res_o    = c_busy_q;

endmodule

// File: tb/ultrasonic_echo_ranger_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for ultrasonic_echo_ranger_top: directed and random tick streams
// with a tick-level predictor of the trigger/echo sequencer; depends on uer_pkg and the rtl
module ultrasonic_echo_ranger_top_tb;
  import uer_pkg::*;

  localparam int COUNT_BITS   = COUNT_BITS_DEF;
  localparam int PIPE_LAT     = 3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_TICKS  = 60;
  localparam logic [63:0] WIDTH_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] DIST_MAX  = (64'd1 << DIST_W) - 64'd1;

  typedef struct packed {
    logic              trig;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              in_range;
    logic              timed_out;
    logic              busy;
  } tick_result_t;

  class ranger_scoreboard;
    tick_result_t pending_results[$];
    int errors;
    logic [TIMEOUT_W-1:0]    timeout_ticks;
    logic [DIST_W-1:0]       min_mm;
    logic [DIST_W-1:0]       max_mm;
    uer_phase_e              phase;
    logic [PHASE_TICK_W-1:0] phase_ticks;
    logic [TIMEOUT_W-1:0]    wait_ticks;
    logic [63:0]             echo_width;
    logic                    echo_prev;

    function new();
      errors        = 0;
      timeout_ticks = TIMEOUT_RST;
      min_mm        = MIN_MM_RST;
      max_mm        = MAX_MM_RST;
      phase         = PH_IDLE;
      phase_ticks   = '0;
      wait_ticks    = '0;
      echo_width    = '0;
      echo_prev     = 1'b0;
    endfunction

    function void set_reg(uer_reg_e idx, logic [31:0] value);
      case (idx)
        REG_TIMEOUT: timeout_ticks = value[TIMEOUT_W-1:0];
        REG_MIN_MM:  min_mm = value[DIST_W-1:0];
        REG_MAX_MM:  max_mm = value[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < 100) $display("error: %s", msg);
      errors++;
    endtask

    // advance the sequencer by one accepted tick and queue its result
    function void predict_tick(logic start, logic echo);
      tick_result_t r;
      logic fell;
      logic [63:0] mm;
      r = '0;
      fell = 1'b0;
      if (phase == PH_IDLE && start) begin
        phase = PH_PRELOW;
        phase_ticks = '0;
      end
      case (phase)
        PH_PRELOW: begin
          phase_ticks++;
          if (phase_ticks >= PRE_LOW_TICKS) begin
            phase = PH_TRIGHI;
            phase_ticks = '0;
          end
        end
        PH_TRIGHI: begin
          r.trig = 1'b1;
          phase_ticks++;
          if (phase_ticks >= TRIG_HIGH_TICKS) begin
            phase = PH_WAITRISE;
            phase_ticks = '0;
            wait_ticks = '0;
            echo_width = '0;
          end
        end
        PH_WAITRISE, PH_MEASURE: begin
          if (wait_ticks != '1) wait_ticks++;
          if (phase == PH_WAITRISE) begin
            // echo already high when waiting starts is not an edge
            if (echo && !echo_prev) begin
              phase = PH_MEASURE;
              echo_width = 64'd1;
            end
          end else if (!echo) begin
            fell = 1'b1;
          end else if (echo_width < WIDTH_MAX) begin
            echo_width++;
          end
          // falling edge wins over a timeout on the same tick
          if (fell) begin
            mm = (echo_width * 64'd100) / 64'd578;
            if (mm > DIST_MAX) mm = DIST_MAX;
            r.distance = mm[DIST_W-1:0];
            r.in_range = (r.distance >= min_mm) && (r.distance <= max_mm);
            r.done = 1'b1;
            phase = PH_IDLE;
          end else if (wait_ticks >= timeout_ticks) begin
            r.done = 1'b1;
            r.timed_out = 1'b1;
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      echo_prev = echo;
      r.busy = (phase != PH_IDLE);
      pending_results.push_back(r);
    endfunction

    task check_result(tick_result_t got);
      tick_result_t want;
      if (pending_results.size() == 0) begin
        report("result transfer with no tick outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got.trig !== want.trig)
        report($sformatf("trig got %0b expected %0b", got.trig, want.trig));
      if (got.done !== want.done)
        report($sformatf("done_res got %0b expected %0b", got.done, want.done));
      if (got.distance !== want.distance)
        report($sformatf("distance_mm got %0d expected %0d", got.distance, want.distance));
      if (got.in_range !== want.in_range)
        report($sformatf("in_range got %0b expected %0b", got.in_range, want.in_range));
      if (got.timed_out !== want.timed_out)
        report($sformatf("timed_out got %0b expected %0b", got.timed_out, want.timed_out));
      if (got.busy !== want.busy)
        report($sformatf("busy_res got %0b expected %0b", got.busy, want.busy));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              start_req;
  logic              echo_in;
  logic              out_valid;
  logic              out_stall;
  logic              trig;
  logic              done_res;
  logic [DIST_W-1:0] distance_mm;
  logic              in_range;
  logic              timed_out;
  logic              busy_res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ranger_scoreboard sb = new();
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int ticks_sent = 0;
  int idle_cycles = 0;

  ultrasonic_echo_ranger_top #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .start_req_i  (start_req),
    .echo_i       (echo_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .trig_o       (trig),
    .done_res_o   (done_res),
    .distance_mm_o(distance_mm),
    .in_range_o   (in_range),
    .timed_out_o  (timed_out),
    .busy_res_o   (busy_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_tick(logic start, logic echo);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    start_req = start;
    echo_in   = echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_tick(start, echo);
    ticks_sent++;
    @(negedge clk);
  endtask

  // start, trigger ticks, low lead-in, echo pulse, falling tick
  task automatic run_measurement(int lead, int width);
    send_tick(1'b1, rbit());
    repeat (PRE_LOW_TICKS + TRIG_HIGH_TICKS - 1) send_tick(rbit(), rbit());
    repeat (lead) send_tick(rbit(), 1'b0);
    repeat (width) send_tick(rbit(), 1'b1);
    send_tick(rbit(), 1'b0);
  endtask

  // finish any measurement in flight, then wait for the pipeline to empty
  task automatic settle();
    while (sb.phase != PH_IDLE) send_tick(1'b0, !sb.echo_prev);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_reg(uer_reg_e idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    sb.set_reg(idx, value);
  endtask

  // receiver: random stall per transfer, one long hold-off on request
  initial begin
    int hold;
    tick_result_t got;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {trig, done_res, distance_mm, in_range, timed_out, busy_res};
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ultrasonic_echo_ranger_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int target;
    int kind;
    int width;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    start_req = 1'b0;
    echo_in   = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // echo high through the trigger, start requests while busy,
    // falling edge before any rising edge, start on the finishing tick
    send_tick(1'b1, 1'b1);
    repeat (PRE_LOW_TICKS + TRIG_HIGH_TICKS - 1) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (6) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          no_idle = 1'b1;
          write_reg(REG_TIMEOUT, $urandom_range(5, 80));
          write_reg(REG_MIN_MM, $urandom_range(0, 10));
          write_reg(REG_MAX_MM, $urandom_range(0, 20));
        end
        1: begin
          write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
          write_reg(REG_MIN_MM, 32'd0);
          write_reg(REG_MAX_MM, 32'hFFFF_FFFF);
        end
        2: begin
          // input side keeps offering while the receiver holds off
          write_reg(REG_TIMEOUT, 32'd1000000);
          write_reg(REG_MIN_MM, 32'd0);
          write_reg(REG_MAX_MM, 32'd173010);
          no_idle = 1'b1;
          hold_req = 1'b1;
        end
        3: begin
          write_reg(REG_TIMEOUT, 32'd0);
          write_reg(REG_MIN_MM, $urandom_range(0, 10));
          write_reg(REG_MAX_MM, $urandom_range(0, 20));
        end
        4: begin
          // bounds crossed, nothing is in range
          write_reg(REG_TIMEOUT, 32'd1);
          write_reg(REG_MIN_MM, 32'd173010);
          write_reg(REG_MAX_MM, 32'd0);
        end
        default: begin
          write_reg(REG_TIMEOUT, $urandom);
          write_reg(REG_MIN_MM, $urandom);
          write_reg(REG_MAX_MM, $urandom);
        end
      endcase
      target = ticks_sent + PHASE_TICKS;
      while (ticks_sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          width = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 400)
                                               : $urandom_range(1, 60);
          run_measurement($urandom_range(1, 10), width);
        end else if (kind == 7) begin
          run_measurement(0, $urandom_range(0, 8));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(rbit(), rbit());
        end
        repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'b0);
      end
      settle();
      no_idle = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("ultrasonic_echo_ranger_top_tb: PASS");
    end else begin
      $display("ultrasonic_echo_ranger_top_tb: FAIL");
    end
    $finish;
  end

endmodule
